@@ hdl/letter_value_command_parser_defines.svh @@
// Assertion macros shared by the letter/value command parser RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef LETTER_VALUE_COMMAND_PARSER_DEFINES_SVH
`define LETTER_VALUE_COMMAND_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LVCP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define LVCP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/lvcp_pkg.sv @@
// Package for the letter/value command parser: ASCII codes, letter codes,
// field mask bits, the record struct and character helpers. No dependencies.
package lvcp_pkg;

   localparam logic [7:0] AsciiLf    = 8'h0A;
   localparam logic [7:0] AsciiCr    = 8'h0D;
   localparam logic [7:0] AsciiMinus = 8'h2D;
   localparam logic [7:0] AsciiZero  = 8'h30;
   localparam logic [7:0] AsciiNine  = 8'h39;
   localparam logic [7:0] AsciiUpA   = 8'h41;
   localparam logic [7:0] AsciiUpZ   = 8'h5A;
   localparam logic [7:0] AsciiLowA  = 8'h61;
   localparam logic [7:0] AsciiLowZ  = 8'h7A;
   localparam logic [7:0] CaseOffset = 8'h20;

   localparam logic [5:0] MaskI = 6'd32;
   localparam logic [5:0] MaskX = 6'd16;
   localparam logic [5:0] MaskY = 6'd8;
   localparam logic [5:0] MaskL = 6'd4;
   localparam logic [5:0] MaskS = 6'd2;
   localparam logic [5:0] MaskM = 6'd1;

   typedef enum logic [2:0] {
      LTR_NONE = 3'd0,
      LTR_I    = 3'd1,
      LTR_X    = 3'd2,
      LTR_Y    = 3'd3,
      LTR_L    = 3'd4,
      LTR_S    = 3'd5,
      LTR_M    = 3'd6
   } letter_type;

   typedef struct packed {
      logic        emit;
      logic [31:0] point_id;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] laser_level;
      logic [31:0] move_speed;
      logic [7:0]  move_mode;
      logic [5:0]  fields_seen;
   } record_type;

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= AsciiLowA && c <= AsciiLowZ) begin
         r = c - CaseOffset;
      end
      return r;
   endfunction

   function automatic letter_type letter_code(input logic [7:0] c);
      letter_type r;
      case (c)
         8'h49: r = LTR_I;
         8'h58: r = LTR_X;
         8'h59: r = LTR_Y;
         8'h4C: r = LTR_L;
         8'h53: r = LTR_S;
         8'h4D: r = LTR_M;
         default: r = LTR_NONE;
      endcase
      return r;
   endfunction

endpackage

@@ hdl/lvcp_parser.sv @@
// Parse state and held field registers of the letter/value command parser.
// Depends on lvcp_pkg and letter_value_command_parser_defines.svh.
`include "letter_value_command_parser_defines.svh"

module lvcp_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [7:0]               rx_byte,
   output lvcp_pkg::record_type     rec
);

   logic                 value_phase_ff, value_phase_in;
   lvcp_pkg::letter_type letter_ff, letter_in;
   logic [31:0]          acc_ff, acc_in;
   logic                 neg_ff, neg_in;
   logic [31:0]          id_ff, id_in;
   logic [31:0]          x_ff, x_in;
   logic [31:0]          y_ff, y_in;
   logic [31:0]          laser_ff, laser_in;
   logic [31:0]          speed_ff, speed_in;
   logic [7:0]           mode_ff, mode_in;
   logic [5:0]           mask_ff, mask_in;

   logic [7:0]  c;
   logic        is_eol, is_letter, is_digit, is_minus;
   logic [31:0] value;
   logic [5:0]  mask_closed;

   always_comb begin
      c         = lvcp_pkg::fold_case(rx_byte);
      is_eol    = (c == lvcp_pkg::AsciiLf) || (c == lvcp_pkg::AsciiCr);
      is_letter = c inside {[lvcp_pkg::AsciiUpA:lvcp_pkg::AsciiUpZ]};
      is_digit  = c inside {[lvcp_pkg::AsciiZero:lvcp_pkg::AsciiNine]};
      is_minus  = (c == lvcp_pkg::AsciiMinus);
      value     = neg_ff ? (32'd0 - acc_ff) : acc_ff;

      id_in       = id_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      laser_in    = laser_ff;
      speed_in    = speed_ff;
      mode_in     = mode_ff;
      mask_closed = mask_ff;

      // a letter or line end closes any open pair
      if (value_phase_ff && (is_eol || is_letter)) begin
         case (letter_ff)
            lvcp_pkg::LTR_I: begin
               id_in       = value;
               mask_closed = mask_ff | lvcp_pkg::MaskI;
            end
            lvcp_pkg::LTR_X: begin
               x_in        = value;
               mask_closed = mask_ff | lvcp_pkg::MaskX;
            end
            lvcp_pkg::LTR_Y: begin
               y_in        = value;
               mask_closed = mask_ff | lvcp_pkg::MaskY;
            end
            lvcp_pkg::LTR_L: begin
               laser_in    = value;
               mask_closed = mask_ff | lvcp_pkg::MaskL;
            end
            lvcp_pkg::LTR_S: begin
               speed_in    = value;
               mask_closed = mask_ff | lvcp_pkg::MaskS;
            end
            lvcp_pkg::LTR_M: begin
               mode_in     = value[7:0];
               mask_closed = mask_ff | lvcp_pkg::MaskM;
            end
            default: begin
               mask_closed = mask_ff;
            end
         endcase
      end

      value_phase_in = value_phase_ff;
      letter_in      = letter_ff;
      acc_in         = acc_ff;
      neg_in         = neg_ff;
      mask_in        = mask_closed;

      if (is_eol) begin
         value_phase_in = 1'b0;
         letter_in      = lvcp_pkg::LTR_NONE;
         acc_in         = '0;
         neg_in         = 1'b0;
         mask_in        = '0;
      end else if (is_letter) begin
         value_phase_in = 1'b1;
         letter_in      = lvcp_pkg::letter_code(c);
         acc_in         = '0;
         neg_in         = 1'b0;
      end else if (is_digit && value_phase_ff) begin
         // acc * 10 + digit; digit is the low nibble of '0'..'9'
         acc_in = (acc_ff << 3) + (acc_ff << 1) + {28'd0, c[3:0]};
      end else if (is_minus && value_phase_ff) begin
         neg_in = 1'b1;
      end

      rec.emit        = is_eol && (mask_closed != '0);
      rec.point_id    = id_in;
      rec.pos_x       = x_in;
      rec.pos_y       = y_in;
      rec.laser_level = laser_in;
      rec.move_speed  = speed_in;
      rec.move_mode   = mode_in;
      rec.fields_seen = mask_closed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_phase_ff <= 1'b0;
         letter_ff      <= lvcp_pkg::LTR_NONE;
         acc_ff         <= '0;
         neg_ff         <= 1'b0;
         id_ff          <= '0;
         x_ff           <= '0;
         y_ff           <= '0;
         laser_ff       <= '0;
         speed_ff       <= '0;
         mode_ff        <= '0;
         mask_ff        <= '0;
      end else if (step) begin
         value_phase_ff <= value_phase_in;
         letter_ff      <= letter_in;
         acc_ff         <= acc_in;
         neg_ff         <= neg_in;
         id_ff          <= id_in;
         x_ff           <= x_in;
         y_ff           <= y_in;
         laser_ff       <= laser_in;
         speed_ff       <= speed_in;
         mode_ff        <= mode_in;
         mask_ff        <= mask_in;
      end
   end

   `LVCP_ASSERT_NEXT(a_eol_clears, clock, reset, step && is_eol,
      (mask_ff == '0) && !value_phase_ff, "line end did not clear the parse state")
   `LVCP_ASSERT_NEXT(a_letter_opens, clock, reset, step && is_letter,
      value_phase_ff && (acc_ff == '0) && !neg_ff, "letter did not open a fresh pair")
   `LVCP_ASSERT_NEXT(a_idle_digit, clock, reset,
      step && !value_phase_ff && !is_letter && !is_eol,
      $stable(acc_ff) && !value_phase_ff, "byte outside a pair changed the value")

endmodule

@@ hdl/letter_value_command_parser.sv @@
// Top level of the letter/value command parser: input register, parser core,
// record output register. Depends on lvcp_pkg, lvcp_parser and the defines header.
`include "letter_value_command_parser_defines.svh"

// Takes one ASCII byte per transaction on req_ and returns one record on rsp_
// for every CR or LF that ends a line holding at least one I, X, Y, L, S or M
// pair. Throughput is one byte per clock while req_ is not stalled. A byte
// is taken into the input register, and the record of a line end is loaded
// from there into the record output register that drives rsp_. The parser
// updates its state straight from the input register, so the only thing that
// stalls req_ is a line end that would produce a record while the previous
// record is still held by rsp_stall; ordinary characters keep flowing in that case.
module letter_value_command_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_point_id,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_laser_level,
   output logic signed [31:0] rsp_move_speed,
   output logic [7:0]         rsp_move_mode,
   output logic [5:0]         rsp_fields_seen
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   lvcp_pkg::record_type rec;
   lvcp_pkg::record_type out_ff;
   logic                 out_free;
   logic                 advance;

   lvcp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .rec     (rec)
   );

   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      advance      = in_valid_ff && (!rec.emit || out_free);
      req_stall    = in_valid_ff && !advance;
      in_valid_in  = req_stall ? in_valid_ff : req_valid;
      rsp_valid_in = (rsp_valid_ff && rsp_stall) || (advance && rec.emit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance && rec.emit) begin
         out_ff <= rec;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_id    = out_ff.point_id;
   assign rsp_pos_x       = out_ff.pos_x;
   assign rsp_pos_y       = out_ff.pos_y;
   assign rsp_laser_level = out_ff.laser_level;
   assign rsp_move_speed  = out_ff.move_speed;
   assign rsp_move_mode   = out_ff.move_mode;
   assign rsp_fields_seen = out_ff.fields_seen;

   `LVCP_ASSERT_NOW(a_no_overwrite, clock, reset, advance && rec.emit,
      !(rsp_valid_ff && rsp_stall), "record loaded over a held record")
   `LVCP_ASSERT_NOW(a_mask_nonzero, clock, reset, rsp_valid_ff,
      out_ff.fields_seen != '0, "record with empty field mask")
   `LVCP_ASSERT_NEXT(a_input_held, clock, reset, req_stall,
      in_valid_ff && $stable(in_byte_ff), "stalled input byte lost")

endmodule

@@ test/tb_letter_value_command_parser.sv @@
// Self-checking testbench for letter_value_command_parser: ASCII command lines in,
// line records out. Depends on lvcp_pkg and the letter_value_command_parser RTL.
`timescale 1ns / 100ps

module tb_letter_value_command_parser;

   localparam int ByteTarget  = 1500;
   localparam int QuietFrom   = 300;
   localparam int QuietTo     = 700;
   localparam int DrainCycles = 10;
   localparam int CycleLimit  = 100000;

   typedef struct {
      bit         gate;    // hold off until every expected record has come
      logic [7:0] ch;
   } feed_item_type;

   typedef struct packed {
      logic [31:0] point_id;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] laser_level;
      logic [31:0] move_speed;
      logic [7:0]  move_mode;
      logic [5:0]  fields_seen;
   } line_record_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_rx_byte = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_point_id;
   logic signed [31:0] rsp_pos_x;
   logic signed [31:0] rsp_pos_y;
   logic signed [31:0] rsp_laser_level;
   logic signed [31:0] rsp_move_speed;
   logic [7:0]         rsp_move_mode;
   logic [5:0]         rsp_fields_seen;

   feed_item_type   pending_bytes[$];
   line_record_type expected_records[$];

   int  bytes_accepted = 0;
   int  records_checked = 0;
   int  mismatches = 0;
   int  holdoffs_done = 0;
   int  cycles = 0;
   wire no_idle = (bytes_accepted >= QuietFrom) && (bytes_accepted < QuietTo);

   // parser state as predicted
   logic                 in_value = 1'b0;
   lvcp_pkg::letter_type open_letter = lvcp_pkg::LTR_NONE;
   logic [31:0]          value_acc = '0;
   logic                 value_neg = 1'b0;
   logic [31:0]          held_id = '0;
   logic [31:0]          held_x = '0;
   logic [31:0]          held_y = '0;
   logic [31:0]          held_laser = '0;
   logic [31:0]          held_speed = '0;
   logic [7:0]           held_mode = '0;
   logic [5:0]           seen_fields = '0;

   letter_value_command_parser dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_point_id    (rsp_point_id),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_laser_level (rsp_laser_level),
      .rsp_move_speed  (rsp_move_speed),
      .rsp_move_mode   (rsp_move_mode),
      .rsp_fields_seen (rsp_fields_seen)
   );

   always #10 clock = ~clock;

   task automatic close_open_pair();
      logic [31:0] v;
      v = value_neg ? (32'd0 - value_acc) : value_acc;
      case (open_letter)
         lvcp_pkg::LTR_I: begin held_id = v;        seen_fields |= lvcp_pkg::MaskI; end
         lvcp_pkg::LTR_X: begin held_x = v;         seen_fields |= lvcp_pkg::MaskX; end
         lvcp_pkg::LTR_Y: begin held_y = v;         seen_fields |= lvcp_pkg::MaskY; end
         lvcp_pkg::LTR_L: begin held_laser = v;     seen_fields |= lvcp_pkg::MaskL; end
         lvcp_pkg::LTR_S: begin held_speed = v;     seen_fields |= lvcp_pkg::MaskS; end
         lvcp_pkg::LTR_M: begin held_mode = v[7:0]; seen_fields |= lvcp_pkg::MaskM; end
         default: ;
      endcase
   endtask

   // Advances the predicted parser by one accepted byte.
   task automatic track_byte(input logic [7:0] raw);
      logic [7:0] c;
      c = raw;
      if (c >= lvcp_pkg::AsciiLowA && c <= lvcp_pkg::AsciiLowZ) c = c - lvcp_pkg::CaseOffset;
      if (c == lvcp_pkg::AsciiLf || c == lvcp_pkg::AsciiCr) begin
         if (in_value) close_open_pair();
         if (seen_fields != '0) begin
            expected_records.push_back('{held_id, held_x, held_y, held_laser,
                                         held_speed, held_mode, seen_fields});
         end
         seen_fields = '0;
         in_value    = 1'b0;
         open_letter = lvcp_pkg::LTR_NONE;
         value_acc   = '0;
         value_neg   = 1'b0;
      end else if (c >= lvcp_pkg::AsciiUpA && c <= lvcp_pkg::AsciiUpZ) begin
         if (in_value) close_open_pair();
         in_value  = 1'b1;
         value_acc = '0;
         value_neg = 1'b0;
         case (c)
            "I": open_letter = lvcp_pkg::LTR_I;
            "X": open_letter = lvcp_pkg::LTR_X;
            "Y": open_letter = lvcp_pkg::LTR_Y;
            "L": open_letter = lvcp_pkg::LTR_L;
            "S": open_letter = lvcp_pkg::LTR_S;
            "M": open_letter = lvcp_pkg::LTR_M;
            default: open_letter = lvcp_pkg::LTR_NONE;
         endcase
      end else if (c >= lvcp_pkg::AsciiZero && c <= lvcp_pkg::AsciiNine) begin
         if (in_value) value_acc = value_acc * 32'd10 + 32'(c - lvcp_pkg::AsciiZero);
      end else if (c == lvcp_pkg::AsciiMinus) begin
         if (in_value) value_neg = 1'b1;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("MISMATCH %s: expected %08h actual %08h (record %0d)",
                  what, want, got, records_checked);
      end
   endtask

   task automatic add_byte(input logic [7:0] b);
      pending_bytes.push_back('{1'b0, b});
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   task automatic add_random_pair(input bit noisy);
      string      known;
      logic [7:0] ltr;
      int         ndig;
      int         r;
      known = "IXYLSM";
      if ($urandom_range(99) < 85) ltr = known[$urandom_range(5)];
      else ltr = 8'(lvcp_pkg::AsciiUpA + $urandom_range(25));
      if ($urandom_range(3) == 0) ltr = ltr + lvcp_pkg::CaseOffset;
      add_byte(ltr);
      if ($urandom_range(4) == 0) add_byte(lvcp_pkg::AsciiMinus);
      r = $urandom_range(99);
      // some values run past 32 bits to exercise wrap
      ndig = (r < 6) ? 0 : (r < 12) ? $urandom_range(14, 10) : $urandom_range(6, 1);
      for (int i = 0; i < ndig; i++) begin
         if (noisy && $urandom_range(9) == 0) add_byte(8'($urandom_range(255)));
         else if ($urandom_range(49) == 0) add_byte(lvcp_pkg::AsciiMinus);
         add_byte(8'(lvcp_pkg::AsciiZero + $urandom_range(9)));
      end
   endtask

   task automatic add_random_line();
      int kind;
      kind = $urandom_range(99);
      if (kind < 8) begin
         repeat ($urandom_range(12)) add_byte(8'($urandom_range(255)));
      end else begin
         repeat ($urandom_range(7)) add_random_pair(kind < 20);
      end
      add_byte($urandom_range(1) ? lvcp_pkg::AsciiLf : lvcp_pkg::AsciiCr);
   endtask

   // Driver: one transaction on req_ at a time, fed from pending_bytes.
   always @(posedge clock) begin : drive_req
      logic          next_valid;
      logic [7:0]    next_byte;
      feed_item_type head;
      if (reset) begin
         req_valid   <= 1'b0;
         req_rx_byte <= '0;
      end else begin
         next_valid = req_valid;
         next_byte  = req_rx_byte;
         if (req_valid && !req_stall) begin
            track_byte(req_rx_byte);
            bytes_accepted++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (pending_bytes.size() > 0 && pending_bytes[0].gate &&
                expected_records.size() == 0) begin
               head = pending_bytes.pop_front();
               holdoffs_done++;
            end
            if (pending_bytes.size() > 0 && !pending_bytes[0].gate &&
                (no_idle || $urandom_range(99) >= 7)) begin
               head       = pending_bytes.pop_front();
               next_byte  = head.ch;
               next_valid = 1'b1;
            end
         end
         req_valid   <= next_valid;
         req_rx_byte <= next_byte;
      end
   end

   // Monitor: checks each record against the oldest prediction.
   always @(posedge clock) begin : watch_rsp
      line_record_type got;
      line_record_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_point_id, rsp_pos_x, rsp_pos_y, rsp_laser_level,
                 rsp_move_speed, rsp_move_mode, rsp_fields_seen};
         if (expected_records.size() == 0) begin
            report_mismatch("unexpected record, fields_seen", '0, 32'(got.fields_seen));
         end else begin
            want = expected_records.pop_front();
            if (got.point_id !== want.point_id)
               report_mismatch("point_id", want.point_id, got.point_id);
            if (got.pos_x !== want.pos_x)
               report_mismatch("pos_x", want.pos_x, got.pos_x);
            if (got.pos_y !== want.pos_y)
               report_mismatch("pos_y", want.pos_y, got.pos_y);
            if (got.laser_level !== want.laser_level)
               report_mismatch("laser_level", want.laser_level, got.laser_level);
            if (got.move_speed !== want.move_speed)
               report_mismatch("move_speed", want.move_speed, got.move_speed);
            if (got.move_mode !== want.move_mode)
               report_mismatch("move_mode", 32'(want.move_mode), 32'(got.move_mode));
            if (got.fields_seen !== want.fields_seen)
               report_mismatch("fields_seen", 32'(want.fields_seen), 32'(got.fields_seen));
         end
         records_checked++;
      end
      rsp_stall <= !reset && !no_idle && ($urandom_range(99) < 7);
   end

   always @(posedge clock) begin : watchdog
      cycles++;
      if (cycles > CycleLimit) begin
         $display("letter_value_command_parser verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      bit gated;
      gated = 1'b0;

      // digits and minus before any letter, lowercase, a space inside a value,
      // trailing minus
      add_text("5-x2 4-");
      add_byte(lvcp_pkg::AsciiCr);
      // junk-only line: no record
      add_byte(8'h00);
      add_byte(8'hFF);
      add_byte(lvcp_pkg::AsciiLf);
      // unknown letter dropped, letter with no digits
      add_text("Q7m");
      add_byte(lvcp_pkg::AsciiLf);
      // 32-bit wrap, doubled minus, back-to-back letters
      add_text("I9999999999--YSL");
      add_byte(lvcp_pkg::AsciiLf);
      add_byte(lvcp_pkg::AsciiCr);

      while (pending_bytes.size() < ByteTarget) begin
         add_random_line();
         if (!gated && pending_bytes.size() > ByteTarget / 2) begin
            pending_bytes.push_back('{1'b1, 8'h00});
            gated = 1'b1;
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_valid) @(posedge clock);
      while (expected_records.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Sent %0d bytes of command lines (directed, well-formed, noisy, empty).",
               bytes_accepted);
      $display("Checked %0d records, %0d hold-off(s) to drain, %0d mismatch(es).",
               records_checked, holdoffs_done, mismatches);
      if (mismatches == 0) begin
         $display("letter_value_command_parser verification clean");
      end else begin
         $display("letter_value_command_parser verification failed");
      end
      $finish;
   end

endmodule
